>>> rtl/mru_pkg.sv
// Shared types and codes for the most-recently-used key list.
package mru_pkg;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_REM_KEY = 3'd1;
  localparam logic [2:0] CMD_REM_AT  = 3'd2;
  localparam logic [2:0] CMD_READ_AT = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam int MAX_SIZE_RESET = 16;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] key;
    logic [3:0]  index;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        hit;
    logic [31:0] read_key;
    logic [4:0]  entry_count;
  } rsp_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;
    logic scan_start;
    logic scan_rd;
    logic scan_next;
    logic mark_hit;
    logic add_miss;
    logic set_oob;
    logic set_ptr_idx;
    logic rd_idx;
    logic mv_rd_dn;
    logic mv_wr_dn;
    logic mv_rd_up;
    logic mv_wr_up;
    logic wr_front;
    logic dec_count;
    logic clr_count;
    logic finish;
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       count_zero;
    logic       idx_oob;
    logic       match;
    logic       scan_last;
    logic       ptr_zero;
    logic       out_free;
  } sts_t;

endpackage

>>> rtl/mru_move_to_front_list.sv
// Most-recently-used key list with move-to-front insertion.
// Sequence: read at, clear, spare and out-of-range requests go from dispatch to the result;
//   a search reads and compares each entry in turn, a shift reads and writes each moved entry,
//   an add ends with the front write and a removal with shortening the list.
// Throughput: one request at a time; the next is taken the cycle after the result registers.
// Reset: asynchronous, active low; empties the list and sets max_size to 16 (or DEPTH).
module mru_move_to_front_list import mru_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rsp_t       out_rsp_o
);

  ctl_t ctl;
  sts_t sts;

  mru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  mru_dpath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

endmodule

>>> rtl/mru_ctrl.sv
// Sequencer that steps each request through scan, shift and result phases.
module mru_ctrl import mru_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_SCAN_RD  = 10'b00_0000_0100,
    S_SCAN_CMP = 10'b00_0000_1000,
    S_MOVE_DN  = 10'b00_0001_0000,
    S_SHIFT_DN = 10'b00_0010_0000,
    S_WR_FRONT = 10'b00_0100_0000,
    S_MOVE_UP  = 10'b00_1000_0000,
    S_SHIFT_UP = 10'b01_0000_0000,
    S_FINISH   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.cmd)
          CMD_ADD: begin
            if (sts_i.count_zero) begin
              ctl_o.add_miss = 1'b1;
              state_d        = S_MOVE_DN;
            end else begin
              ctl_o.scan_start = 1'b1;
              state_d          = S_SCAN_RD;
            end
          end
          CMD_REM_KEY: begin
            if (sts_i.count_zero) begin
              state_d = S_FINISH;
            end else begin
              ctl_o.scan_start = 1'b1;
              state_d          = S_SCAN_RD;
            end
          end
          CMD_REM_AT: begin
            if (sts_i.idx_oob) begin
              ctl_o.set_oob = 1'b1;
              state_d       = S_FINISH;
            end else begin
              ctl_o.set_ptr_idx = 1'b1;
              state_d           = S_MOVE_UP;
            end
          end
          CMD_READ_AT: begin
            if (sts_i.idx_oob) begin
              ctl_o.set_oob = 1'b1;
            end else begin
              ctl_o.rd_idx = 1'b1;
            end
            state_d = S_FINISH;
          end
          CMD_CLEAR: begin
            ctl_o.clr_count = 1'b1;
            state_d         = S_FINISH;
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_SCAN_RD: begin
        ctl_o.scan_rd = 1'b1;
        state_d       = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts_i.match) begin
          ctl_o.mark_hit = 1'b1;
          state_d        = (sts_i.cmd == CMD_ADD) ? S_MOVE_DN : S_MOVE_UP;
        end else if (sts_i.scan_last) begin
          if (sts_i.cmd == CMD_ADD) begin
            ctl_o.add_miss = 1'b1;
            state_d        = S_MOVE_DN;
          end else begin
            state_d = S_FINISH;
          end
        end else begin
          ctl_o.scan_next = 1'b1;
          state_d         = S_SCAN_RD;
        end
      end
      S_MOVE_DN: begin
        if (sts_i.ptr_zero) begin
          state_d = S_WR_FRONT;
        end else begin
          ctl_o.mv_rd_dn = 1'b1;
          state_d        = S_SHIFT_DN;
        end
      end
      S_SHIFT_DN: begin
        ctl_o.mv_wr_dn = 1'b1;
        state_d        = S_MOVE_DN;
      end
      S_WR_FRONT: begin
        ctl_o.wr_front = 1'b1;
        state_d        = S_FINISH;
      end
      S_MOVE_UP: begin
        // close the gap, then shorten the list
        if (sts_i.scan_last) begin
          ctl_o.dec_count = 1'b1;
          state_d         = S_FINISH;
        end else begin
          ctl_o.mv_rd_up = 1'b1;
          state_d        = S_SHIFT_UP;
        end
      end
      S_SHIFT_UP: begin
        ctl_o.mv_wr_up = 1'b1;
        state_d        = S_MOVE_UP;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/mru_dpath.sv
// Key store, pointers, size register and output register of the list.
module mru_dpath import mru_pkg::*; #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rsp_t       out_rsp_o,
  input  ctl_t       ctl_i,
  output sts_t       sts_o
);

  localparam int CW        = $clog2(DEPTH + 1);
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB        = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int MaxReset  = (DEPTH < MAX_SIZE_RESET) ? DEPTH : MAX_SIZE_RESET;

  logic [KEY_BITS-1:0] mem_q [DEPTH];
  logic [KEY_BITS-1:0] rd_q;

  logic [2:0]          cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [3:0]          idx_q;
  logic [CW-1:0]       ptr_q, ptr_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       max_q;
  logic                hit_q, status_q;
  logic                out_valid_q;
  rsp_t                out_q;

  logic                we, re;
  logic [AW-1:0]       wa, ra;
  logic [KEY_BITS-1:0] wd;
  logic [CW:0]         ptr_inc;
  logic [CW-1:0]       miss_pos;

  assign ptr_inc  = {1'b0, ptr_q} + {{CW{1'b0}}, 1'b1};
  assign miss_pos = (count_q == max_q) ? (max_q - CW'(1)) : count_q;

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = ptr_q[AW-1:0];
    wd = rd_q;
    re = 1'b0;
    ra = ptr_q[AW-1:0];
    if (ctl_i.mv_wr_dn || ctl_i.mv_wr_up) begin
      we = 1'b1;
    end else if (ctl_i.wr_front) begin
      we = 1'b1;
      wa = '0;
      wd = key_q;
    end
    if (ctl_i.scan_rd) begin
      re = 1'b1;
    end else if (ctl_i.mv_rd_dn) begin
      re = 1'b1;
      ra = AW'(ptr_q - CW'(1));
    end else if (ctl_i.mv_rd_up) begin
      re = 1'b1;
      ra = AW'(ptr_inc);
    end else if (ctl_i.rd_idx) begin
      re = 1'b1;
      ra = AW'(idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (ctl_i.scan_start) begin
      ptr_d = '0;
    end else if (ctl_i.scan_next || ctl_i.mv_wr_up) begin
      ptr_d = ptr_inc[CW-1:0];
    end else if (ctl_i.mv_wr_dn) begin
      ptr_d = ptr_q - CW'(1);
    end else if (ctl_i.add_miss) begin
      ptr_d = miss_pos;
    end else if (ctl_i.set_ptr_idx) begin
      ptr_d = CW'(idx_q);
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.add_miss) begin
      count_d = miss_pos + CW'(1);
    end else if (ctl_i.dec_count) begin
      count_d = count_q - CW'(1);
    end else if (ctl_i.clr_count) begin
      count_d = '0;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q <= in_req_i.cmd;
      key_q <= KEY_BITS'(in_req_i.key[CB-1:0]);
      idx_q <= in_req_i.index;
    end
    ptr_q <= ptr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      max_q       <= CW'(MaxReset);
      hit_q       <= 1'b0;
      status_q    <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i && (count_q == '0)) begin
        if (cfg_wdata_i == 5'd0) begin
          max_q <= CW'(1);
        end else if (int'(cfg_wdata_i) > DEPTH) begin
          max_q <= CW'(DEPTH);
        end else begin
          max_q <= CW'(cfg_wdata_i);
        end
      end
      if (ctl_i.latch) begin
        hit_q    <= 1'b0;
        status_q <= STATUS_OK;
      end else begin
        if (ctl_i.mark_hit) begin
          hit_q <= 1'b1;
        end
        if (ctl_i.set_oob) begin
          status_q <= STATUS_RANGE;
        end
      end
      if (ctl_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.finish) begin
      out_q.status      <= status_q;
      out_q.hit         <= hit_q;
      out_q.read_key    <= ((cmd_q == CMD_READ_AT) && (status_q == STATUS_OK))
                           ? 32'(rd_q[CB-1:0]) : 32'd0;
      out_q.entry_count <= 5'(count_q);
    end
  end

  assign sts_o.cmd        = cmd_q;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.idx_oob    = (int'(idx_q) >= int'(count_q));
  assign sts_o.match      = (rd_q == key_q);
  assign sts_o.scan_last  = (ptr_inc >= {1'b0, count_q});
  assign sts_o.ptr_zero   = (ptr_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
